/* hdl/grc_pkg.sv */
// Shared types and constants for the graph reachability and cycle block.
// Item formats and op codes used by the top level and its port checker.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package grc_pkg;

  localparam int unsigned VtxW            = 6;
  localparam int unsigned VerticesDefault = 64;

  typedef enum logic [1:0] {
    OP_ADD_VERTEX = 2'd0,
    OP_ADD_EDGE   = 2'd1,
    OP_REACH      = 2'd2,
    OP_CYCLE      = 2'd3
  } op_e;

  typedef struct packed {
    op_e             op;
    logic [VtxW-1:0] vertex_from;
    logic [VtxW-1:0] vertex_to;
  } in_t;

  typedef struct packed {
    logic found;
    logic error;
  } out_t;

endpackage

`default_nettype wire

/* hdl/graph_reachability_and_cycle.sv */
// Top level of the graph reachability and cycle block: adjacency memory,
// presence bits and the frontier walk sequencer.
// Depends on grc_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Holds a directed graph in a one-port-read, one-port-write adjacency memory
// of min(VERTICES, 64) rows (vertex numbers are 6 bits), one row per source
// vertex, with a valid bit per row so reset takes effect at once and no
// clearing pass is needed. One item is worked at a time; a finished result
// waits in an output register while the next item is taken. Add edge reads,
// modifies and writes back the source row. A reachability query that does not
// resolve at once walks the graph: it reads one adjacency row per reached
// vertex, start included, through the single read port, waits for the row
// whenever no other vertex is pending, and stops early once the target shows
// up. A cycle query runs one such walk from each vertex in turn and stops at
// the first cycle found.
module graph_reachability_and_cycle #(
  parameter int unsigned VERTICES = grc_pkg::VerticesDefault
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire grc_pkg::in_t  in_data_i,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output grc_pkg::out_t      out_data_o
);
  import grc_pkg::*;

  localparam int unsigned MaxV = 2 ** VtxW;
  localparam int unsigned NV   = (VERTICES < MaxV) ? VERTICES : MaxV;
  localparam int unsigned IW   = $clog2(NV);
  localparam logic [VtxW:0]  NvL  = (VtxW + 1)'(NV);
  localparam logic [IW-1:0]  Last = IW'(NV - 1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EDGE = 4'b0010,
    S_WALK = 4'b0100,
    S_RESP = 4'b1000
  } state_e;

  state_e          state_q, state_d;
  logic [NV-1:0]   pres_q, pres_d;
  logic [NV-1:0]   row_vld_q, row_vld_d;
  logic [NV-1:0]   pend_q, pend_d;
  logic [NV-1:0]   vis_q, vis_d;
  logic            tgt_ok_q, tgt_ok_d;
  logic            cyc_q, cyc_d;
  logic            infl_q, infl_d;
  logic            rd_vld_q, rd_vld_d;
  logic            out_vld_q, out_vld_d;
  logic [IW-1:0]   tgt_q, tgt_d;
  logic [IW-1:0]   src_q, src_d;
  logic [IW-1:0]   edge_from_q, edge_from_d;
  logic [IW-1:0]   edge_to_q, edge_to_d;
  out_t            res_q, res_d;
  out_t            out_q;

  logic [NV-1:0]   adj_mem_q [NV];
  logic [NV-1:0]   rd_data_q;
  logic            rd_en, wr_en;
  logic [IW-1:0]   rd_addr, wr_addr;
  logic [NV-1:0]   wr_data;

  logic            in_acc, out_load;
  logic            from_ok, to_ok;
  logic [IW-1:0]   from_idx, to_idx, src_nxt;
  logic [NV-1:0]   sel, row, fresh;
  logic [IW-1:0]   sel_idx;
  logic            hit, walk_end;

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  assign from_ok  = {1'b0, in_data_i.vertex_from} < NvL;
  assign to_ok    = {1'b0, in_data_i.vertex_to} < NvL;
  assign from_idx = in_data_i.vertex_from[IW-1:0];
  assign to_idx   = in_data_i.vertex_to[IW-1:0];
  assign src_nxt  = src_q + 1'b1;

  // Walk datapath: lowest pending vertex, returned row, newly reached set.
  always_comb begin
    sel     = pend_q & (~pend_q + NV'(1));
    sel_idx = '0;
    for (int i = 0; i < NV; i++) begin
      if (sel[i]) begin
        sel_idx = sel_idx | IW'(i);
      end
    end
    row      = (infl_q && rd_vld_q) ? rd_data_q : '0;
    fresh    = row & ~vis_q;
    hit      = tgt_ok_q && fresh[tgt_q];
    walk_end = (pend_q == '0) && (fresh == '0);
  end

  always_comb begin
    state_d     = state_q;
    pres_d      = pres_q;
    row_vld_d   = row_vld_q;
    pend_d      = pend_q;
    vis_d       = vis_q;
    tgt_ok_d    = tgt_ok_q;
    cyc_d       = cyc_q;
    infl_d      = infl_q;
    tgt_d       = tgt_q;
    src_d       = src_q;
    edge_from_d = edge_from_q;
    edge_to_d   = edge_to_q;
    res_d       = res_q;
    rd_en       = 1'b0;
    rd_addr     = sel_idx;
    wr_en       = 1'b0;
    wr_addr     = edge_from_q;
    wr_data     = ((rd_vld_q) ? rd_data_q : '0) | (NV'(1) << edge_to_q);
    out_load    = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          res_d   = '0;
          state_d = S_RESP;
          case (in_data_i.op)
            OP_ADD_VERTEX: begin
              if (from_ok) begin
                pres_d[from_idx] = 1'b1;
              end
            end
            OP_ADD_EDGE: begin
              if (from_ok && to_ok) begin
                pres_d[from_idx] = 1'b1;
                pres_d[to_idx]   = 1'b1;
                edge_from_d      = from_idx;
                edge_to_d        = to_idx;
                rd_en            = 1'b1;
                rd_addr          = from_idx;
                state_d          = S_EDGE;
              end
            end
            OP_REACH: begin
              if (in_data_i.vertex_from == in_data_i.vertex_to) begin
                res_d.found = 1'b1;
              end else if (!from_ok || !pres_q[from_idx]) begin
                res_d.error = 1'b1;
              end else begin
                pend_d   = NV'(1) << from_idx;
                vis_d    = NV'(1) << from_idx;
                tgt_d    = to_idx;
                tgt_ok_d = to_ok;
                cyc_d    = 1'b0;
                infl_d   = 1'b0;
                state_d  = S_WALK;
              end
            end
            OP_CYCLE: begin
              pend_d   = NV'(1);
              vis_d    = '0;
              tgt_d    = '0;
              src_d    = '0;
              tgt_ok_d = 1'b1;
              cyc_d    = 1'b1;
              infl_d   = 1'b0;
              state_d  = S_WALK;
            end
            default: begin
              state_d = S_RESP;
            end
          endcase
        end
      end
      S_EDGE: begin
        wr_en                  = 1'b1;
        row_vld_d[edge_from_q] = 1'b1;
        state_d                = S_RESP;
      end
      S_WALK: begin
        pend_d = (pend_q & ~sel) | fresh;
        vis_d  = vis_q | fresh;
        rd_en  = (pend_q != '0) && !hit;
        infl_d = rd_en;
        if (hit) begin
          res_d.found = 1'b1;
          state_d     = S_RESP;
        end else if (walk_end) begin
          if (!cyc_q || src_q == Last) begin
            state_d = S_RESP;
          end else begin
            src_d  = src_nxt;
            tgt_d  = src_nxt;
            pend_d = NV'(1) << src_nxt;
            vis_d  = '0;
          end
        end
      end
      S_RESP: begin
        if (!out_vld_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign rd_vld_d  = rd_en ? row_vld_q[rd_addr] : rd_vld_q;
  assign out_vld_d = out_load || (out_vld_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      pres_q    <= '0;
      row_vld_q <= '0;
      pend_q    <= '0;
      vis_q     <= '0;
      tgt_ok_q  <= 1'b0;
      cyc_q     <= 1'b0;
      infl_q    <= 1'b0;
      rd_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      pres_q    <= pres_d;
      row_vld_q <= row_vld_d;
      pend_q    <= pend_d;
      vis_q     <= vis_d;
      tgt_ok_q  <= tgt_ok_d;
      cyc_q     <= cyc_d;
      infl_q    <= infl_d;
      rd_vld_q  <= rd_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tgt_q       <= tgt_d;
    src_q       <= src_d;
    edge_from_q <= edge_from_d;
    edge_to_q   <= edge_to_d;
    res_q       <= res_d;
    if (out_load) begin
      out_q <= res_q;
    end
  end

  // Adjacency memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      adj_mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= adj_mem_q[rd_addr];
    end
  end

endmodule

`default_nettype wire

/* hdl/grc_checker.sv */
// Port-level checker for the graph reachability and cycle block,
// attached to the top level by the bind statement below.
// Depends on grc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module grc_checker (
  input wire logic          clk_i,
  input wire logic          rst_ni,
  input wire logic          in_valid_i,
  input wire logic          in_stall_o,
  input wire grc_pkg::in_t  in_data_i,
  input wire logic          out_valid_o,
  input wire logic          out_stall_i,
  input wire grc_pkg::out_t out_data_o
);
  import grc_pkg::*;

  logic in_acc;
  assign in_acc = in_valid_i && !in_stall_o;

  // hold a stalled result item
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result item changed or dropped");

  // take one item at a time
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> in_stall_o)
    else $error("input taken while an item is in work");

  a_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.found && out_data_o.error))
    else $error("result item flags both found and error");

  a_add_vertex: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_data_i.op == OP_ADD_VERTEX && !out_valid_o
    |-> ##2 out_valid_o && !out_data_o.found && !out_data_o.error)
    else $error("add vertex result item late or wrong");

endmodule

bind graph_reachability_and_cycle grc_checker u_grc_checker (.*);

`default_nettype wire
